[hdl/regex_unicode_escape_rewriter_assert.svh]
// Assertion macros for the unicode escape rewriter checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef REGEX_UNICODE_ESCAPE_REWRITER_ASSERT_SVH
`define REGEX_UNICODE_ESCAPE_REWRITER_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define RUER_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define RUER_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hdl/ruer_pkg.sv]
// Shared types, constants and helper functions of the unicode escape rewriter.
// No dependencies.
`default_nettype none

package ruer_pkg;

   localparam int CharW     = 16;
   localparam int DigitW    = 7;
   localparam int BufDepth  = 3;
   localparam int BufIdxW   = $clog2(BufDepth);
   localparam int RunDepth  = 8;
   localparam int RunIdxW   = $clog2(RunDepth);
   localparam int RunCntW   = $clog2(RunDepth + 1);

   localparam logic [CharW-1:0] CharBackslash = 16'h005C;
   localparam logic [CharW-1:0] CharLowerU    = 16'h0075;
   localparam logic [CharW-1:0] CharNul       = 16'h0000;

   // Text that stands for a NUL: backslash, x, 0, 0
   localparam logic [3:0][CharW-1:0] NulText = {16'h0030, 16'h0030, 16'h0078, 16'h005C};

   typedef struct packed {
      logic              escape_pending;
      logic              in_unicode_escape;
      logic [2:0]        hex_count;
      logic [CharW-1:0]  hex_accum;
   } state_type;

   typedef struct packed {
      logic               en;
      logic [BufIdxW-1:0] idx;
      logic [DigitW-1:0]  data;
   } buf_wr_type;

   typedef struct packed {
      logic [RunDepth-1:0][CharW-1:0] chars;
      logic [RunCntW-1:0]             count;
      logic                           pattern_end;
   } run_type;

   // {valid, value} of a hex digit character
   function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   function automatic logic is_meta(input logic [CharW-1:0] c);
      logic r;
      unique case (c)
         16'h005E, 16'h0024, 16'h005C, 16'h002E, 16'h002A, 16'h002B, 16'h003F,
         16'h0028, 16'h0029, 16'h007B, 16'h007D, 16'h005B, 16'h005D, 16'h007C: begin
            r = 1'b1;
         end
         default: begin
            r = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[hdl/ruer_req_if.sv]
// Request channel of the unicode escape rewriter: one pattern code unit.
// Depends on ruer_pkg.
`default_nettype none

interface ruer_req_if;
   logic                       valid;
   logic                       ready;
   logic [ruer_pkg::CharW-1:0] in_char;
   logic                       pattern_end;

   modport source (output valid, output in_char, output pattern_end, input ready);
   modport sink   (input valid, input in_char, input pattern_end, output ready);
endinterface

`default_nettype wire

[hdl/ruer_rsp_if.sv]
// Result channel of the unicode escape rewriter: one rewritten code unit.
// Depends on ruer_pkg.
`default_nettype none

interface ruer_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ruer_pkg::CharW-1:0] out_char;
   logic                       run_last;
   logic                       out_pattern_end;

   modport source (output valid, output out_char, output run_last, output out_pattern_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input out_pattern_end,
                   output ready);
endinterface

`default_nettype wire

[hdl/ruer_decode.sv]
// Per-character decode: from the current state, the digit buffer and one request,
// builds the run of result characters, the next state and the digit buffer write.
// Depends on ruer_pkg.
`default_nettype none

module ruer_decode #(
   parameter int MAX_HEX_DIGITS = 4
) (
   input  wire ruer_pkg::state_type                                    state,
   input  wire logic [ruer_pkg::BufDepth-1:0][ruer_pkg::DigitW-1:0]    digit_buf,
   input  wire logic [ruer_pkg::CharW-1:0]                             in_char,
   input  wire logic                                                   pattern_end,
   output ruer_pkg::state_type                                         next_state,
   output ruer_pkg::buf_wr_type                                        buf_wr,
   output ruer_pkg::run_type                                           run
);

   function automatic ruer_pkg::run_type push(input ruer_pkg::run_type r,
                                              input logic [ruer_pkg::CharW-1:0] ch);
      ruer_pkg::run_type o;
      o = r;
      if (r.count < ruer_pkg::RunCntW'(ruer_pkg::RunDepth)) begin
         o.chars[r.count[ruer_pkg::RunIdxW-1:0]] = ch;
         o.count = r.count + 1'b1;
      end
      return o;
   endfunction

   function automatic ruer_pkg::run_type push_nul(input ruer_pkg::run_type r);
      ruer_pkg::run_type o;
      o = r;
      for (int k = 0; k < 4; k++) begin
         o = push(o, ruer_pkg::NulText[k]);
      end
      return o;
   endfunction

   // 'u' then the buffered digits of a short run
   function automatic ruer_pkg::run_type push_flush(
         input ruer_pkg::run_type r, input logic [2:0] cnt,
         input logic [ruer_pkg::BufDepth-1:0][ruer_pkg::DigitW-1:0] bv);
      ruer_pkg::run_type o;
      o = push(r, ruer_pkg::CharLowerU);
      for (int k = 0; k < ruer_pkg::BufDepth; k++) begin
         if (3'(k) < cnt) begin
            o = push(o, ruer_pkg::CharW'(bv[k]));
         end
      end
      return o;
   endfunction

   ruer_pkg::run_type   r;
   ruer_pkg::state_type s;
   ruer_pkg::buf_wr_type wr;
   logic [ruer_pkg::BufDepth-1:0][ruer_pkg::DigitW-1:0] bv;
   logic [4:0]              hv;
   logic [ruer_pkg::CharW-1:0] decoded;
   logic                    do_plain;

   always_comb begin
      r        = '0;
      s        = state;
      wr       = '0;
      hv       = ruer_pkg::hex_value(in_char);
      decoded  = {state.hex_accum[ruer_pkg::CharW-5:0], hv[3:0]};
      do_plain = 1'b0;

      if (state.in_unicode_escape) begin
         if (hv[4]) begin
            if ((4'(state.hex_count) + 4'd1) >= 4'(MAX_HEX_DIGITS)) begin
               // full escape: emit the decoded character, NUL as text, a metacharacter behind a backslash
               s.in_unicode_escape = 1'b0;
               s.hex_count         = 3'd0;
               s.hex_accum         = '0;
               if (decoded == ruer_pkg::CharNul) begin
                  r = push_nul(r);
               end else begin
                  if (ruer_pkg::is_meta(decoded)) begin
                     r = push(r, ruer_pkg::CharBackslash);
                  end
                  r = push(r, decoded);
               end
            end else begin
               // collect one more digit
               if (state.hex_count < 3'(ruer_pkg::BufDepth)) begin
                  wr.en   = 1'b1;
                  wr.idx  = state.hex_count[ruer_pkg::BufIdxW-1:0];
                  wr.data = in_char[ruer_pkg::DigitW-1:0];
               end
               s.hex_count = state.hex_count + 3'd1;
               s.hex_accum = decoded;
            end
         end else begin
            // short run ended by a non-hex character
            r = push_flush(r, state.hex_count, digit_buf);
            s.in_unicode_escape = 1'b0;
            s.hex_count         = 3'd0;
            s.hex_accum         = '0;
            do_plain            = 1'b1;
         end
      end else if (state.escape_pending) begin
         s.escape_pending = 1'b0;
         if (in_char == ruer_pkg::CharLowerU) begin
            s.in_unicode_escape = 1'b1;
            s.hex_count         = 3'd0;
            s.hex_accum         = '0;
         end else begin
            r = push(r, ruer_pkg::CharBackslash);
            r = push(r, in_char);
         end
      end else begin
         do_plain = 1'b1;
      end

      // ordinary character handling
      if (do_plain) begin
         if (in_char == ruer_pkg::CharBackslash) begin
            s.escape_pending = 1'b1;
         end else if (in_char == ruer_pkg::CharNul) begin
            r = push_nul(r);
         end else begin
            r = push(r, in_char);
         end
      end

      // buffer as it stands after this request's write
      bv = digit_buf;
      if (wr.en) begin
         bv[wr.idx] = wr.data;
      end

      // pattern end: flush what is open and return to idle
      if (pattern_end) begin
         if (s.in_unicode_escape) begin
            r = push_flush(r, s.hex_count, bv);
         end
         if (s.escape_pending) begin
            r = push(r, ruer_pkg::CharBackslash);
         end
         s = '0;
      end
      r.pattern_end = pattern_end;
   end

   assign next_state = s;
   assign buf_wr     = wr;
   assign run        = r;

endmodule

`default_nettype wire

[hdl/ruer_serializer.sv]
// Result register: holds one run of up to eight characters and shifts them out
// one per cycle while rsp_chan is ready. Depends on ruer_pkg and ruer_rsp_if.
`default_nettype none

module ruer_serializer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire ruer_pkg::run_type run,
   output logic                   load_ready,
   ruer_rsp_if.source             rsp_chan
);

   logic [ruer_pkg::RunDepth-1:0][ruer_pkg::CharW-1:0] chars_ff, chars_in;
   logic [ruer_pkg::RunCntW-1:0] remain_ff, remain_in;
   logic                         end_ff, end_in;
   logic                         take;
   logic                         on_last;

   assign on_last = (remain_ff == ruer_pkg::RunCntW'(1));
   assign take    = rsp_chan.valid && rsp_chan.ready;

   // a new run may load when empty or when the last character leaves now
   assign load_ready = (remain_ff == '0) || (on_last && rsp_chan.ready);

   // next run contents
   always_comb begin
      chars_in  = chars_ff;
      remain_in = remain_ff;
      end_in    = end_ff;
      if (load) begin
         chars_in  = run.chars;
         remain_in = run.count;
         end_in    = run.pattern_end;
      end else if (take) begin
         chars_in  = chars_ff >> ruer_pkg::CharW;
         remain_in = remain_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
      end_ff   <= end_in;
   end

   // result channel
   assign rsp_chan.valid           = (remain_ff != '0);
   assign rsp_chan.out_char        = chars_ff[0];
   assign rsp_chan.run_last        = on_last;
   assign rsp_chan.out_pattern_end = end_ff && on_last;

endmodule

`default_nettype wire

[hdl/regex_unicode_escape_rewriter.sv]
// Top level of the unicode escape rewriter: escape state, digit buffer, decode
// and the result serializer. Depends on ruer_pkg, ruer_req_if, ruer_rsp_if,
// ruer_decode and ruer_serializer.
//
//   channel   | direction | payload                               | accepted when
//   ----------+-----------+---------------------------------------+-----------------
//   req_chan  | in        | in_char[15:0], pattern_end            | valid && ready
//   rsp_chan  | out       | out_char[15:0], run_last,             | valid && ready
//             |           | out_pattern_end                       |
//
// A request is decoded in the cycle it is taken and its run of 0 to 8 results
// is shown from the next cycle on, one result per cycle while rsp_chan is ready.
// A request's results hold the result port until the last of them leaves; the next
// request is taken in the cycle the last of them leaves, so with one result per
// request and rsp_chan ready the rate is one per cycle.
// Synchronous active-high reset clears the escape state and empties the run.
// A stall on rsp_chan holds the current result and, once the run is down to
// its last result, stops req_chan too.
`default_nettype none

module regex_unicode_escape_rewriter #(
   parameter int MAX_HEX_DIGITS = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ruer_req_if.sink   req_chan,
   ruer_rsp_if.source rsp_chan
);

   ruer_pkg::state_type  state_ff, state_in;
   ruer_pkg::buf_wr_type buf_wr;
   ruer_pkg::run_type    run;
   logic [ruer_pkg::BufDepth-1:0][ruer_pkg::DigitW-1:0] digit_buf_ff;
   logic                 load_ready;
   logic                 accept;

   assign req_chan.ready = load_ready;
   assign accept         = req_chan.valid && load_ready;

   // decode of the incoming character
   ruer_decode #(
      .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
   ) u_decode (
      .state       (state_ff),
      .digit_buf   (digit_buf_ff),
      .in_char     (req_chan.in_char),
      .pattern_end (req_chan.pattern_end),
      .next_state  (state_in),
      .buf_wr      (buf_wr),
      .run         (run)
   );

   // escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // buffered digit characters of an open escape
   always_ff @(posedge clock) begin
      if (accept && buf_wr.en) begin
         digit_buf_ff[buf_wr.idx] <= buf_wr.data;
      end
   end

   // result register and output sequencing
   ruer_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .run        (run),
      .load_ready (load_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

[hdl/ruer_checker.sv]
// Port-level checks of the unicode escape rewriter, bound to the top level.
// Depends on regex_unicode_escape_rewriter_assert.svh.
`default_nettype none
`include "regex_unicode_escape_rewriter_assert.svh"

module ruer_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] out_char,
   input wire logic        run_last,
   input wire logic        out_pattern_end
);

   // a stalled result holds
   `RUER_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(out_char) && $stable(run_last))

   // the end of a pattern always closes a run
   `RUER_ASSERT_NOW(a_end_is_last, rsp_valid && out_pattern_end, run_last)

   // a request is taken only while the last result of the run leaves
   `RUER_ASSERT_NOW(a_req_waits_run, req_valid && req_ready && rsp_valid, rsp_ready && run_last)

   // a run that is not finished goes on
   `RUER_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !run_last, rsp_valid)

endmodule

bind regex_unicode_escape_rewriter ruer_checker u_ruer_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .out_char        (rsp_chan.out_char),
   .run_last        (rsp_chan.run_last),
   .out_pattern_end (rsp_chan.out_pattern_end)
);

`default_nettype wire
